// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the RPN stack calculator: request and result
// payloads, opcodes, status codes, controller states and command signals.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_DROP = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_UNDERFLOW = 2'd1,
    STS_DIV_ZERO  = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] op_result;
    logic [6:0]         stack_depth;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EXEC,
    ST_DIVIDE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH,
    CMD_DROP,
    CMD_NOP,
    CMD_ERROR,
    CMD_READ_A,
    CMD_READ_B,
    CMD_ARITH,
    CMD_DIV_ZERO,
    CMD_DIV_START,
    CMD_DIV_WB
  } cmd_e;

  typedef struct packed {
    cmd_e    cmd;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       sp_zero;
    logic       sp_full;
    logic       sp_lt2;
    logic       b_zero;
    logic       div_done;
  } dp_status_t;

endpackage

// ===== rtl/rsc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_divider
// Iterative signed divider, one quotient bit per cycle on the magnitudes,
// truncating toward zero. done_o pulses once the quotient is ready.
// ----------------------------------------------------------------------------
module rsc_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rsc_pkg::DATA_WIDTH-1:0]  dividend_i,
  input  logic [rsc_pkg::DATA_WIDTH-1:0]  divisor_i,
  output logic                            done_o,
  output logic [rsc_pkg::DATA_WIDTH-1:0]  quotient_o
);
  import rsc_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dvs_q;
  logic                  neg_q;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   shifted, diff;

  assign mag_a = dividend_i[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - dividend_i) : dividend_i;
  assign mag_b = divisor_i[DATA_WIDTH-1]  ? (DATA_WIDTH'(0) - divisor_i)  : divisor_i;

  // restoring step: bring in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, quo_q[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (!diff[DATA_WIDTH]) begin
      rem_d = diff[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_d = shifted[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= dividend_i[DATA_WIDTH-1] ^ divisor_i[DATA_WIDTH-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_WIDTH'(0) - quo_q) : quo_q;

endmodule

// ===== rtl/rsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_datapath
// Stack memory, stack pointer, operand registers, arithmetic unit, divider
// and the registered result; acts on one command from the controller a cycle.
// ----------------------------------------------------------------------------
module rsc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsc_pkg::req_t       req_i,
  input  rsc_pkg::ctrl_cmd_t  cmd_i,
  output rsc_pkg::dp_status_t status_o,
  output logic                result_valid_o,
  output rsc_pkg::rsp_t       result_o
);
  import rsc_pkg::*;

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] a_q;
  req_t                  req_q;
  logic [PTR_W-1:0]      sp_q, sp_d;
  logic [PTR_W-1:0]      sp_m1, sp_m2;
  logic                  rd_en;
  logic [ADDR_W-1:0]     raddr;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] arith_res;
  logic                  div_start, div_done;
  logic [DATA_WIDTH-1:0] div_quot;
  logic                  respond;
  status_e               rsp_status;
  logic [DATA_WIDTH-1:0] rsp_value;
  logic                  out_valid_q;
  rsp_t                  out_q;

  assign sp_m1 = sp_q - PTR_W'(1);
  assign sp_m2 = sp_q - PTR_W'(2);

  // b is the second entry, in rdata_q once both reads are done
  always_comb begin
    case (req_q.opcode)
      OP_ADD:  arith_res = a_q + rdata_q;
      OP_SUB:  arith_res = a_q - rdata_q;
      OP_MUL:  arith_res = a_q * rdata_q;
      default: arith_res = '0;
    endcase
  end

  always_comb begin
    sp_d       = sp_q;
    rd_en      = 1'b0;
    raddr      = sp_m1[ADDR_W-1:0];
    we         = 1'b0;
    waddr      = sp_m2[ADDR_W-1:0];
    wdata      = arith_res;
    div_start  = 1'b0;
    respond    = 1'b0;
    rsp_status = STS_OK;
    rsp_value  = '0;
    case (cmd_i.cmd)
      CMD_PUSH: begin
        we      = 1'b1;
        waddr   = sp_q[ADDR_W-1:0];
        wdata   = DATA_WIDTH'(req_q.push_value);
        sp_d    = sp_q + PTR_W'(1);
        respond = 1'b1;
      end
      CMD_DROP: begin
        sp_d    = sp_m1;
        respond = 1'b1;
      end
      CMD_NOP: begin
        respond = 1'b1;
      end
      CMD_ERROR: begin
        respond    = 1'b1;
        rsp_status = cmd_i.status;
      end
      CMD_READ_A: begin
        rd_en = 1'b1;
      end
      CMD_READ_B: begin
        rd_en = 1'b1;
        raddr = sp_m2[ADDR_W-1:0];
      end
      CMD_ARITH: begin
        we        = 1'b1;
        sp_d      = sp_m1;
        respond   = 1'b1;
        rsp_value = arith_res;
      end
      CMD_DIV_ZERO: begin
        sp_d       = sp_m2;
        respond    = 1'b1;
        rsp_status = STS_DIV_ZERO;
      end
      CMD_DIV_START: begin
        div_start = 1'b1;
      end
      CMD_DIV_WB: begin
        we        = 1'b1;
        wdata     = div_quot;
        sp_d      = sp_m1;
        respond   = 1'b1;
        rsp_value = div_quot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CMD_LOAD) begin
      req_q <= req_i;
    end
    if (cmd_i.cmd == CMD_READ_B) begin
      a_q <= rdata_q;
    end
    if (respond) begin
      out_q.status      <= rsp_status;
      out_q.op_result   <= rsp_value;
      out_q.stack_depth <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      out_valid_q <= respond;
    end
  end

  rsc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (rdata_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign status_o.opcode   = req_q.opcode;
  assign status_o.sp_zero  = (sp_q == '0);
  assign status_o.sp_full  = (sp_q >= PTR_W'(STACK_DEPTH));
  assign status_o.sp_lt2   = (sp_q < PTR_W'(2));
  assign status_o.b_zero   = (rdata_q == '0);
  assign status_o.div_done = div_done;

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// ===== rtl/rsc_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_controller
// Sequencer of the calculator: takes a request, checks the stack, steps the
// datapath through operand reads, execution and division.
// ----------------------------------------------------------------------------
module rsc_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rsc_pkg::dp_status_t status_i,
  output rsc_pkg::ctrl_cmd_t  cmd_o
);
  import rsc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        if (status_i.opcode inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV} && !status_i.sp_lt2) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (status_i.opcode == OP_DIV && !status_i.b_zero) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.cmd    = CMD_NONE;
    cmd_o.status = STS_OK;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.cmd = CMD_LOAD;
        end
      end
      ST_DECODE: begin
        case (status_i.opcode)
          OP_PUSH: begin
            if (status_i.sp_full) begin
              cmd_o.cmd    = CMD_ERROR;
              cmd_o.status = STS_FULL;
            end else begin
              cmd_o.cmd = CMD_PUSH;
            end
          end
          OP_DROP: begin
            if (status_i.sp_zero) begin
              cmd_o.cmd    = CMD_ERROR;
              cmd_o.status = STS_UNDERFLOW;
            end else begin
              cmd_o.cmd = CMD_DROP;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (status_i.sp_lt2) begin
              cmd_o.cmd    = CMD_ERROR;
              cmd_o.status = STS_UNDERFLOW;
            end else begin
              cmd_o.cmd = CMD_READ_A;
            end
          end
          default: cmd_o.cmd = CMD_NOP;
        endcase
      end
      ST_READ: cmd_o.cmd = CMD_READ_B;
      ST_EXEC: begin
        if (status_i.opcode != OP_DIV) begin
          cmd_o.cmd = CMD_ARITH;
        end else if (status_i.b_zero) begin
          cmd_o.cmd = CMD_DIV_ZERO;
        end else begin
          cmd_o.cmd = CMD_DIV_START;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.cmd = CMD_DIV_WB;
        end
      end
      default: cmd_o.cmd = CMD_NONE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Integer reverse-Polish calculator on a 64-entry stack of 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode, push_value) is taken on a rising edge with start high
//   and busy low. Every request gives exactly one result on result_o, marked
//   by result_valid_o for a single cycle; the receiver cannot stall it, so it
//   must take the result in that cycle.
//   From the accepting edge to the result strobe, each request passes through:
//     push, drop, unused opcodes and stack errors: the decode state
//     add, subtract, multiply and divide by zero: decode, read and execute
//     divide: decode, read, execute and the one-bit-per-cycle divider (32 steps)
//   busy drops in the cycle the strobe rises, so the next request can be issued
//   while the result is strobed; the stack memory port (one read per operand)
//   and the divider set how long each request takes.
//   Reset clears the stack pointer, the sequencer and the result strobe; the
//   stack memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rsc_pkg::req_t req_i,
  output logic          result_valid_o,
  output rsc_pkg::rsp_t result_o
);
  import rsc_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  rsc_controller u_controller (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  rsc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== tb/rpn_stack_calculator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_test
// Self-checking bench for the RPN stack calculator. Requests go in through the
// start/busy handshake in random bursts. A stack model in the bench predicts
// each result, and every strobed result is compared field by field with the
// oldest prediction. Directed cases cover the corners, stack-full runs fill
// the stack, and depth-steered random traffic does the rest.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_test;
  import rsc_pkg::*;

  localparam logic [2:0]  OP_UNUSED_6   = 3'd6;
  localparam logic [2:0]  OP_UNUSED_7   = 3'd7;
  localparam logic [31:0] MIN_VALUE     = 32'h8000_0000;
  localparam logic [31:0] MAX_VALUE     = 32'h7fff_ffff;
  localparam int          CYCLE_LIMIT   = 900_000;
  localparam int          SETTLE_CYCLES = 48;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  result_valid_o;
  rsp_t  result_o;

  // stack model and pending results
  logic [31:0] stack_mem [STACK_DEPTH];
  int          stack_ptr = 0;
  rsp_t        expected_q [$];
  rsp_t        want;
  int          fail_count = 0;
  int          burst_left = 0;
  int          cycle_count = 0;

  rpn_stack_calculator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // applies one request to the stack model and returns the result it gives
  function automatic rsp_t predict_step(req_t r);
    rsp_t        o;
    logic [31:0] a, b, ma, mb, q;
    o.status    = STS_OK;
    o.op_result = '0;
    case (r.opcode)
      OP_PUSH: begin
        if (stack_ptr >= STACK_DEPTH) begin
          o.status = STS_FULL;
        end else begin
          stack_mem[stack_ptr] = r.push_value;
          stack_ptr++;
        end
      end
      OP_DROP: begin
        if (stack_ptr == 0) o.status = STS_UNDERFLOW;
        else stack_ptr--;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (stack_ptr < 2) begin
          o.status = STS_UNDERFLOW;
        end else begin
          a = stack_mem[stack_ptr - 1];
          b = stack_mem[stack_ptr - 2];
          stack_ptr -= 2;
          if (r.opcode == OP_DIV && b == '0) begin
            o.status = STS_DIV_ZERO;
          end else begin
            case (r.opcode)
              OP_ADD: q = a + b;
              OP_SUB: q = a - b;
              OP_MUL: q = a * b;
              default: begin
                // divide on magnitudes so MIN / -1 comes back as MIN
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q  = ma / mb;
                if (a[31] ^ b[31]) q = -q;
              end
            endcase
            stack_mem[stack_ptr] = q;
            stack_ptr++;
            o.op_result = q;
          end
        end
      end
      default: ;
    endcase
    o.stack_depth = stack_ptr[6:0];
    return o;
  endfunction

  function automatic logic [31:0] random_value();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(4))
        0:       return MIN_VALUE;
        1:       return MAX_VALUE;
        2:       return '0;
        3:       return '1;
        default: return 32'd1;
      endcase
    end
    // small values make quotients and zero divisors common
    if (sel < 5) return 32'($signed($urandom_range(16)) - 8);
    return $urandom();
  endfunction

  // mostly well-formed traffic steered by the model depth, a little noise
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.push_value = random_value();
    pick = $urandom_range(99);
    if (pick < 4) begin
      r.opcode = 3'($urandom_range(7));
    end else if (stack_ptr < 2) begin
      if (pick < 88) r.opcode = OP_PUSH;
      else if (pick < 94) r.opcode = OP_DROP;
      else r.opcode = 3'(OP_ADD + $urandom_range(3));
    end else if (stack_ptr > 12) begin
      if (pick < 24) r.opcode = OP_PUSH;
      else if (pick < 85) r.opcode = 3'(OP_ADD + $urandom_range(3));
      else r.opcode = OP_DROP;
    end else begin
      if (pick < 48) r.opcode = OP_PUSH;
      else if (pick < 90) r.opcode = 3'(OP_ADD + $urandom_range(3));
      else r.opcode = OP_DROP;
    end
    return r;
  endfunction

  // holds start until the request is taken, then idles between bursts
  task automatic send_request(input logic [2:0] op, input logic [31:0] value);
    req_t r;
    r.opcode     = op;
    r.push_value = value;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_q = {expected_q, predict_step(r)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(4, 40))
        @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_request(OP_DROP, $urandom());       // drop on empty stack
    send_request(OP_ADD, $urandom());        // binary op on empty stack
    send_request(OP_PUSH, MAX_VALUE);
    send_request(OP_DIV, $urandom());        // binary op with one entry
    send_request(OP_PUSH, MAX_VALUE);
    send_request(OP_ADD, MAX_VALUE);         // wraps to -2
    send_request(OP_PUSH, MIN_VALUE);
    send_request(OP_SUB, $urandom());
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, 32'd5);
    send_request(OP_DIV, '1);                // zero divisor pops both
    send_request(OP_PUSH, '1);
    send_request(OP_PUSH, MIN_VALUE);
    send_request(OP_DIV, '0);                // MIN / -1
    send_request(OP_PUSH, -32'sd3);
    send_request(OP_PUSH, 32'd7);
    send_request(OP_DIV, $urandom());        // truncates toward zero
    send_request(OP_MUL, $urandom());
    send_request(OP_UNUSED_6, MAX_VALUE);
    send_request(OP_UNUSED_7, MIN_VALUE);
    send_request(OP_DROP, '0);
    send_request(OP_DROP, '1);
    send_request(OP_DROP, '0);
  endtask

  task automatic test_stack_full();
    while (stack_ptr < STACK_DEPTH) send_request(OP_PUSH, random_value());
    send_request(OP_PUSH, random_value());   // push on full stack
    send_request(3'(OP_ADD + $urandom_range(3)), $urandom());
    send_request(OP_PUSH, random_value());
    send_request(OP_PUSH, random_value());
  endtask

  task automatic test_random_traffic(input int count);
    req_t r;
    int   done;
    done = 0;
    while (done < count) begin
      r = random_request();
      send_request(r.opcode, r.push_value);
      if (r.opcode <= OP_DIV) done++;
    end
  endtask

  task automatic test_pause_until_drained();
    repeat (3) send_request(OP_PUSH, random_value());
    send_request(OP_DIV, $urandom());
    send_request(OP_MUL, $urandom());
    wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (expected_q.size() == 0) begin
        log_failure($sformatf("unexpected result: status %0d result %0d depth %0d",
                              result_o.status, result_o.op_result, result_o.stack_depth));
      end else begin
        want = expected_q.pop_front();
        if (result_o.status !== want.status || result_o.op_result !== want.op_result ||
            result_o.stack_depth !== want.stack_depth) begin
          log_failure($sformatf(
            "mismatch: expected status %0d result %0d depth %0d, got %0d %0d %0d",
            want.status, want.op_result, want.stack_depth,
            result_o.status, result_o.op_result, result_o.stack_depth));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_stack_full();
    test_random_traffic(780);
    test_pause_until_drained();
    test_random_traffic(780);
    test_stack_full();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      log_failure($sformatf("%0d expected results never arrived", expected_q.size()));
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rsc_pkg.sv
rtl/rsc_divider.sv
rtl/rsc_datapath.sv
rtl/rsc_controller.sv
rtl/rpn_stack_calculator.sv
tb/rpn_stack_calculator_test.sv
